@@ hdl/sliding_window_rate_meter_assert.svh @@
// assertion macros for the meter's top module
`ifndef SLIDING_WINDOW_RATE_METER_ASSERT_SVH
`define SLIDING_WINDOW_RATE_METER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SWRM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/swrm_pkg.sv @@
package swrm_pkg;

    localparam int TIME_W     = 32;
    localparam int BYTES_W    = 24;
    localparam int SLOT_B_W   = 32;
    localparam int WT_W       = 48;
    localparam int TOTAL_W    = 64;
    localparam int RATE_W     = 32;
    localparam int MEM_W      = SLOT_B_W + TIME_W;
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_RESET   = 2'd2,
        CMD_STANDBY = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hdl/swrm_div.sv @@
module swrm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swrm_pkg::t_div_req                  i_req,
    output swrm_pkg::t_div_stat                 o_stat,
    output logic [swrm_pkg::DIVIDEND_W-1:0]     o_quotient
);
    import swrm_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    shifted;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    // restoring step: one quotient bit per cycle, dividend shifts out as quotient shifts in
    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

@@ hdl/sliding_window_rate_meter.sv @@
// Byte-rate meter over a ring of SLOT_COUNT slots of SLOT_SECONDS each. The slot byte counts
// and slot numbers sit in one single-port memory. Requests are taken one at a time and each
// gives one result. Add, reset and standby requests first turn the time into a slot number
// with a reciprocal multiply followed by up to two compare-and-subtract fix-up steps. An add
// then does a read-modify-write of one memory entry, and reads the next entry too when the
// ring steps. A query divides the window total by the elapsed seconds on a 48-step bit-serial
// divider. A query in standby or with no elapsed time answers zero without the divider. A wait
// on the output holds the finished request in S_DONE. Meter resets clear the slot memory at
// once through one valid bit per slot, with no clearing pass. The next request is taken while
// a result still waits on the output register.
module sliding_window_rate_meter #(
    parameter int SLOT_COUNT   = 32,
    parameter int SLOT_SECONDS = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic [swrm_pkg::TIME_W-1:0]     i_now_seconds,
    input  logic [swrm_pkg::BYTES_W-1:0]    i_byte_count,
    input  logic                            i_standby_flag,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [swrm_pkg::RATE_W-1:0]     o_rate,
    output logic [swrm_pkg::TOTAL_W-1:0]    o_lifetime_bytes
);
    import swrm_pkg::*;

    `include "sliding_window_rate_meter_assert.svh"

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int SS_W   = $clog2(SLOT_SECONDS + 1);
    localparam int PROD_W = TIME_W + SS_W;
    localparam logic [SS_W-1:0] SS_K = SS_W'(SLOT_SECONDS);
    localparam logic [TIME_W-1:0] SLOT_RECIP = TIME_W'(64'hFFFF_FFFF / 64'(SLOT_SECONDS));

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_SLOT = 10'b0000000010,
        S_CHK  = 10'b0000000100,
        S_ADV  = 10'b0000001000,
        S_UPD  = 10'b0000010000,
        S_QMUL = 10'b0000100000,
        S_QCHK = 10'b0001000000,
        S_QDIV = 10'b0010000000,
        S_DONE = 10'b0100000000,
        S_SFIX = 10'b1000000000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [TIME_W-1:0]     r_now, n_now;
    logic [BYTES_W-1:0]    r_bytes, n_bytes;
    logic                  r_flag, n_flag;
    logic [TIME_W-1:0]     r_now_slot, n_now_slot;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [WT_W-1:0]       r_wt, n_wt;
    logic [TIME_W-1:0]     r_ws, n_ws;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic                  r_standby, n_standby;
    logic [TIME_W-1:0]     r_clr_slot, n_clr_slot;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [SLOT_B_W-1:0]   r_cur_bytes, n_cur_bytes;
    logic [TIME_W-1:0]     r_cur_time, n_cur_time;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [RATE_W-1:0]     r_res_rate, n_res_rate;
    logic                  r_out_valid, n_out_valid;
    logic [RATE_W-1:0]     r_out_rate;
    logic [TOTAL_W-1:0]    r_out_life;

    logic [MEM_W-1:0]      r_mem [SLOT_COUNT];
    logic [MEM_W-1:0]      r_rd_data;
    logic                  mem_re;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_ra;
    logic [IDX_W-1:0]      mem_wa;
    logic [MEM_W-1:0]      mem_wd;

    t_div_req              div_req;
    t_div_stat             div_stat;
    logic [DIVIDEND_W-1:0] div_quo;

    logic                  in_acc;
    logic                  out_load;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W-1:0]      ent_sel;
    logic [SLOT_B_W-1:0]   ent_bytes;
    logic [TIME_W-1:0]     ent_time;
    logic [SLOT_B_W:0]     grown;
    logic [SLOT_B_W-1:0]   sat_bytes;
    logic [SLOT_B_W-1:0]   delta;
    logic                  q_pos;
    logic [DIVISOR_W-1:0]  elapsed;
    logic [RATE_W-1:0]     quo_sat;
    logic [2*TIME_W-1:0]   slot_prod;
    logic [TIME_W-1:0]     slot_rem;
    logic                  slot_fix;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign idx_next = (r_idx == IDX_W'(SLOT_COUNT - 1)) ? '0 : r_idx + 1'b1;
    assign ent_sel  = (r_state == S_ADV) ? idx_next : r_idx;
    // a slot not written since the last meter reset holds zero bytes at the reset's slot
    assign ent_bytes = r_valid[ent_sel] ? r_rd_data[MEM_W-1:TIME_W] : '0;
    assign ent_time  = r_valid[ent_sel] ? r_rd_data[TIME_W-1:0] : r_clr_slot;

    assign grown     = {1'b0, r_cur_bytes} + (SLOT_B_W + 1)'(r_bytes);
    assign sat_bytes = grown[SLOT_B_W] ? '1 : grown[SLOT_B_W-1:0];
    assign delta     = sat_bytes - r_cur_bytes;

    // reciprocal estimate is at most two below the true slot number, never above
    assign slot_prod = {{TIME_W{1'b0}}, r_now} * {{TIME_W{1'b0}}, SLOT_RECIP};
    assign slot_rem  = r_now - (r_now_slot * TIME_W'(SS_K));
    assign slot_fix  = slot_rem >= TIME_W'(SS_K);

    // window start in seconds is below now only when elapsed is positive and fits 32 bits
    assign q_pos   = r_prod < PROD_W'(r_now);
    assign elapsed = r_now - r_prod[TIME_W-1:0];
    assign quo_sat = (div_quo[DIVIDEND_W-1:RATE_W] != '0) ? '1 : div_quo[RATE_W-1:0];

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_wt;
        div_req.divisor  = elapsed;
        if (r_state == S_QCHK) begin
            div_req.start = !r_standby && q_pos;
        end
    end

    swrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_now       = r_now;
        n_bytes     = r_bytes;
        n_flag      = r_flag;
        n_now_slot  = r_now_slot;
        n_idx       = r_idx;
        n_wt        = r_wt;
        n_ws        = r_ws;
        n_total     = r_total;
        n_standby   = r_standby;
        n_clr_slot  = r_clr_slot;
        n_valid     = r_valid;
        n_cur_bytes = r_cur_bytes;
        n_cur_time  = r_cur_time;
        n_prod      = r_prod;
        n_res_rate  = r_res_rate;
        mem_re      = 1'b0;
        mem_ra      = r_idx;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = {sat_bytes, r_cur_time};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = t_cmd'(i_command);
                    n_now   = i_now_seconds;
                    n_bytes = i_byte_count;
                    n_flag  = i_standby_flag;
                    n_state = (t_cmd'(i_command) == CMD_QUERY) ? S_QMUL : S_SLOT;
                end
            end
            S_SLOT: begin
                n_now_slot = slot_prod[2*TIME_W-1:TIME_W];
                n_state    = S_SFIX;
            end
            S_SFIX: begin
                if (slot_fix) begin
                    n_now_slot = r_now_slot + 1'b1;
                end else begin
                    n_res_rate = '0;
                    n_state    = S_DONE;
                    unique case (r_cmd)
                        CMD_ADD: begin
                            mem_re  = 1'b1;
                            mem_ra  = r_idx;
                            n_state = S_CHK;
                        end
                        CMD_RESET: begin
                            n_valid    = '0;
                            n_clr_slot = r_now_slot;
                            n_idx      = '0;
                            n_wt       = '0;
                            n_ws       = r_now_slot;
                        end
                        CMD_STANDBY: begin
                            n_standby = r_flag;
                            if (!r_flag) begin
                                n_valid    = '0;
                                n_clr_slot = r_now_slot;
                                n_idx      = '0;
                                n_wt       = '0;
                                n_ws       = r_now_slot;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK: begin
                if (r_now_slot > ent_time) begin
                    mem_re  = 1'b1;
                    mem_ra  = idx_next;
                    n_state = S_ADV;
                end else begin
                    n_cur_bytes = ent_bytes;
                    n_cur_time  = ent_time;
                    n_state     = S_UPD;
                end
            end
            S_ADV: begin
                // outgoing slot leaves the window
                n_wt        = r_wt - WT_W'(ent_bytes);
                n_ws        = ent_time;
                n_cur_bytes = '0;
                n_cur_time  = r_now_slot;
                n_idx       = idx_next;
                n_state     = S_UPD;
            end
            S_UPD: begin
                if (r_wt == '0) begin
                    n_ws = r_now_slot;
                end
                n_wt           = r_wt + WT_W'(delta);
                n_total        = r_total + TOTAL_W'(r_bytes);
                mem_we         = 1'b1;
                mem_wa         = r_idx;
                n_valid[r_idx] = 1'b1;
                n_state        = S_DONE;
            end
            S_QMUL: begin
                n_prod  = PROD_W'(r_ws) * PROD_W'(SS_K);
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (!r_standby && q_pos) begin
                    n_state = S_QDIV;
                end else begin
                    n_res_rate = '0;
                    n_state    = S_DONE;
                end
            end
            S_QDIV: begin
                if (div_stat.done) begin
                    n_res_rate = quo_sat;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_wt        <= '0;
            r_ws        <= '0;
            r_total     <= '0;
            r_standby   <= 1'b1;
            r_clr_slot  <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wt        <= n_wt;
            r_ws        <= n_ws;
            r_total     <= n_total;
            r_standby   <= n_standby;
            r_clr_slot  <= n_clr_slot;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_now       <= n_now;
        r_bytes     <= n_bytes;
        r_flag      <= n_flag;
        r_now_slot  <= n_now_slot;
        r_cur_bytes <= n_cur_bytes;
        r_cur_time  <= n_cur_time;
        r_prod      <= n_prod;
        r_res_rate  <= n_res_rate;
        if (out_load) begin
            r_out_rate <= r_res_rate;
            r_out_life <= r_total;
        end
    end

    // slot store: bytes in the upper half, slot number in the lower half
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_rate           = r_out_rate;
    assign o_lifetime_bytes = r_out_life;

    `SWRM_ASSERT_IMP(a_mem_rw_excl, mem_we, !mem_re, "slot store read and written together")
    `SWRM_ASSERT_NEXT(a_acc_stalls, in_acc, o_in_stall, "request taken while one is in work")
    `SWRM_ASSERT_IMP(a_div_idle, div_req.start, !div_stat.busy, "divider started while busy")
    `SWRM_ASSERT_IMP(a_idx_range, 1'b1, r_idx <= IDX_W'(SLOT_COUNT - 1), "slot index out of ring")
    `SWRM_ASSERT_IMP(a_out_from_done, $rose(o_out_valid), $past(r_state) == S_DONE, "stray result")

endmodule

@@ verif/sliding_window_rate_meter_test.sv @@
module sliding_window_rate_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swrm_pkg::*;

    localparam int SLOT_COUNT   = 32;
    localparam int SLOT_SECONDS = 1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [RATE_W-1:0]  rate;
        logic [TOTAL_W-1:0] lifetime;
    } t_reading;

    class meter_scoreboard;
        logic [SLOT_B_W-1:0] slot_bytes [SLOT_COUNT];
        logic [TIME_W-1:0]   slot_time [SLOT_COUNT];
        int unsigned         slot_idx;
        logic [WT_W-1:0]     window_total;
        logic [TIME_W-1:0]   window_start;
        logic [TOTAL_W-1:0]  lifetime;
        bit                  standby_on;
        t_reading            expected_readings[$];
        int                  failures;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_bytes[i] = '0;
                slot_time[i]  = '0;
            end
            slot_idx     = 0;
            window_total = '0;
            window_start = '0;
            lifetime     = '0;
            standby_on   = 1'b1;
            failures     = 0;
        endfunction

        function void clear_meter(logic [TIME_W-1:0] now_slot);
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_bytes[i] = '0;
                slot_time[i]  = now_slot;
            end
            slot_idx     = 0;
            window_total = '0;
            window_start = now_slot;
        endfunction

        function void add_bytes(logic [TIME_W-1:0] now_slot, logic [BYTES_W-1:0] bytes);
            int unsigned idx;
            logic [SLOT_B_W:0] grown;
            idx = slot_idx;
            // step to the next slot, dropping whatever it still held
            if (now_slot > slot_time[idx]) begin
                idx = (idx + 1) % SLOT_COUNT;
                window_total    = window_total - {16'd0, slot_bytes[idx]};
                window_start    = slot_time[idx];
                slot_bytes[idx] = '0;
                slot_time[idx]  = now_slot;
            end
            slot_idx = idx;
            if (window_total == '0)
                window_start = now_slot;
            grown = {1'b0, slot_bytes[idx]} + {9'd0, bytes};
            if (grown[SLOT_B_W])
                grown = {1'b0, {SLOT_B_W{1'b1}}};
            window_total    = window_total + {16'd0, grown[SLOT_B_W-1:0] - slot_bytes[idx]};
            slot_bytes[idx] = grown[SLOT_B_W-1:0];
            lifetime        = lifetime + {40'd0, bytes};
        endfunction

        function logic [RATE_W-1:0] rate_now(logic [TIME_W-1:0] now);
            longint elapsed;
            logic [63:0] divisor;
            logic [63:0] quotient;
            if (standby_on)
                return '0;
            elapsed = longint'({32'd0, now}) - longint'({32'd0, window_start}) * SLOT_SECONDS;
            if (elapsed <= 0)
                return '0;
            divisor  = elapsed;
            quotient = {16'd0, window_total} / divisor;
            if (quotient > 64'hFFFF_FFFF)
                return '1;
            return quotient[RATE_W-1:0];
        endfunction

        function void note_request(t_cmd cmd, logic [TIME_W-1:0] now,
                                   logic [BYTES_W-1:0] bytes, logic flag);
            t_reading want;
            logic [TIME_W-1:0] now_slot;
            now_slot  = now / SLOT_SECONDS;
            want.rate = '0;
            case (cmd)
                CMD_ADD: add_bytes(now_slot, bytes);
                CMD_QUERY: want.rate = rate_now(now);
                CMD_RESET: clear_meter(now_slot);
                CMD_STANDBY: begin
                    standby_on = flag;
                    if (!flag)
                        clear_meter(now_slot);
                end
            endcase
            want.lifetime = lifetime;
            expected_readings = {expected_readings, want};
        endfunction

        function void note_failure(string what, logic [63:0] want, logic [63:0] got);
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        endfunction

        function void check_reading(logic [RATE_W-1:0] rate, logic [TOTAL_W-1:0] lifetime_out);
            t_reading want;
            if (expected_readings.size() == 0) begin
                note_failure("unrequested result (lifetime shown)", '0, lifetime_out);
                return;
            end
            want = expected_readings.pop_front();
            if (rate !== want.rate)
                note_failure("rate", 64'(want.rate), 64'(rate));
            if (lifetime_out !== want.lifetime)
                note_failure("lifetime_bytes", want.lifetime, lifetime_out);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_command;
    logic [TIME_W-1:0]    i_now_seconds;
    logic [BYTES_W-1:0]   i_byte_count;
    logic                 i_standby_flag;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [RATE_W-1:0]    o_rate;
    logic [TOTAL_W-1:0]   o_lifetime_bytes;

    meter_scoreboard      sb;
    int unsigned          in_idle_pct;
    int unsigned          out_idle_pct;
    int unsigned          requests_sent;
    int unsigned          cycle_count;
    int unsigned          hold_left;
    bit                   hold_trigger;
    bit                   hold_seen;
    logic [TIME_W-1:0]    wall_time;

    sliding_window_rate_meter #(
        .SLOT_COUNT   (SLOT_COUNT),
        .SLOT_SECONDS (SLOT_SECONDS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_now_seconds    (i_now_seconds),
        .i_byte_count     (i_byte_count),
        .i_standby_flag   (i_standby_flag),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rate           (o_rate),
        .o_lifetime_bytes (o_lifetime_bytes)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reading(o_rate, o_lifetime_bytes);
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    task automatic send_request(t_cmd cmd, logic [TIME_W-1:0] now,
                                logic [BYTES_W-1:0] bytes, logic flag);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_now_seconds  <= now;
        i_byte_count   <= bytes;
        i_standby_flag <= flag;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(cmd, now, bytes, flag);
        requests_sent++;
    endtask

    task automatic random_request();
        int unsigned move;
        int unsigned pick;
        t_cmd cmd;
        logic [TIME_W-1:0] now;
        logic [BYTES_W-1:0] bytes;
        logic flag;
        move = $urandom_range(99);
        if (move < 40)
            ;
        else if (move < 85)
            wall_time = wall_time + 1;
        else if (move < 93)
            wall_time = wall_time + $urandom_range(40, 2);
        else if (move < 96)
            wall_time = wall_time - $urandom_range(5, 1);
        else if (move < 98)
            wall_time = 32'hFFFF_FF00 + $urandom_range(255);
        else
            wall_time = $urandom;
        pick = $urandom_range(99);
        if (pick < 74)
            cmd = CMD_ADD;
        else if (pick < 96)
            cmd = CMD_QUERY;
        else if (pick < 98)
            cmd = CMD_RESET;
        else
            cmd = CMD_STANDBY;
        pick = $urandom_range(99);
        if (pick < 8)
            bytes = '1;
        else if (pick < 14)
            bytes = '0;
        else if (pick < 70)
            bytes = BYTES_W'($urandom_range(5000));
        else
            bytes = BYTES_W'($urandom);
        flag = 1'($urandom_range(1));
        now  = wall_time;
        // queries slightly in the past can give zero or negative elapsed time
        if (cmd == CMD_QUERY && $urandom_range(7) == 0)
            now = wall_time - $urandom_range(3);
        send_request(cmd, now, bytes, flag);
    endtask

    // one stretch of metering: usually leave standby, then a run of random requests
    task automatic run_episode();
        int unsigned len;
        len = $urandom_range(90, 10);
        if ($urandom_range(7) != 0)
            send_request(CMD_STANDBY, wall_time, BYTES_W'($urandom), 1'b0);
        repeat (len) random_request();
    endtask

    // two saturated slots so the window total passes 32 bits
    task automatic overflow_burst();
        logic [TIME_W-1:0] base;
        base = wall_time + 10;
        send_request(CMD_STANDBY, base, '0, 1'b0);
        repeat (258) send_request(CMD_ADD, base, '1, 1'b0);
        repeat (258) send_request(CMD_ADD, base + 1, '1, 1'b1);
        send_request(CMD_QUERY, base + 1, '0, 1'b0);
        send_request(CMD_QUERY, base + 3, '1, 1'b1);
        wall_time = base + 3;
    endtask

    task automatic run_phase(int unsigned count);
        int unsigned phase_end;
        phase_end = requests_sent + count;
        while (requests_sent < phase_end)
            run_episode();
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_ADD;
        i_now_seconds  = '0;
        i_byte_count   = '0;
        i_standby_flag = 1'b0;
        i_out_stall    = 1'b0;
        in_idle_pct    = 31;
        out_idle_pct   = 60;
        requests_sent  = 0;
        cycle_count    = 0;
        hold_left      = 0;
        hold_trigger   = 1'b0;
        hold_seen      = 1'b0;
        wall_time      = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_request(CMD_QUERY,   32'd0,        '0,          1'b0);  // standby after reset
        send_request(CMD_ADD,     32'd5,        '1,          1'b1);  // counted in standby
        send_request(CMD_STANDBY, 32'd10,       '0,          1'b0);
        send_request(CMD_QUERY,   32'd10,       '0,          1'b0);  // no elapsed time
        send_request(CMD_QUERY,   32'd9,        '0,          1'b1);  // negative elapsed
        send_request(CMD_ADD,     32'd10,       '0,          1'b0);  // empty window restart
        send_request(CMD_ADD,     32'd10,       '1,          1'b0);
        send_request(CMD_ADD,     32'd11,       24'd1000,    1'b0);
        send_request(CMD_QUERY,   32'd13,       '1,          1'b0);
        send_request(CMD_ADD,     32'hFFFF_FFFF, 24'd500,    1'b1);
        send_request(CMD_QUERY,   32'hFFFF_FFFF, '0,         1'b0);
        send_request(CMD_ADD,     32'd0,        '0,          1'b0);  // time wrapped back
        send_request(CMD_QUERY,   32'd1,        '0,          1'b0);
        send_request(CMD_RESET,   32'd20,       '1,          1'b1);
        send_request(CMD_QUERY,   32'd25,       '0,          1'b0);
        send_request(CMD_STANDBY, 32'd30,       '0,          1'b1);
        send_request(CMD_QUERY,   32'd40,       '0,          1'b0);
        send_request(CMD_ADD,     32'd41,       24'd77,      1'b0);
        send_request(CMD_STANDBY, 32'd42,       '1,          1'b1);
        send_request(CMD_STANDBY, 32'd42,       '0,          1'b0);
        send_request(CMD_ADD,     32'd43,       24'hABCDEF,  1'b0);
        send_request(CMD_ADD,     32'd44,       24'h543210,  1'b1);
        send_request(CMD_QUERY,   32'd45,       '1,          1'b1);
        wall_time = 32'd1000;

        run_phase(220);
        in_idle_pct  = 60;
        out_idle_pct = 31;
        run_phase(220);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        // long receiver hold while requests keep coming
        hold_trigger = ~hold_trigger;
        run_phase(80);
        overflow_burst();
        run_phase(10);

        i_in_valid <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_readings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
